@@ src/wqs_pkg.sv @@
// Shared types and constants for the weighted quantile selector.
package wqs_pkg;

    // Field widths.
    localparam int LABEL_W  = 32;
    localparam int WEIGHT_W = 32;
    localparam int ALPHA_W  = 16;
    localparam int STATUS_W = 2;

    // Default capacity of the sorting chain.
    localparam int MAX_ITEMS_DEF = 64;

    // Register file.
    localparam int              PADDR_W     = 2;
    localparam int              PDATA_W     = 32;
    localparam logic [PADDR_W-1:0] ADDR_ALPHA = 2'd0;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'h8000;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROP = 2'd2;

    // One stored (label, weight) pair.
    typedef struct packed {
        logic signed [LABEL_W-1:0] label;
        logic [WEIGHT_W-1:0]       weight;
    } pair_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

endpackage

@@ src/wqs_cell.sv @@
// One insertion-sort cell: holds a pair and trades it with its neighbors.
module wqs_cell (
    input  logic               aclk,
    input  wqs_pkg::cell_ctrl_t ctrl,
    input  wqs_pkg::pair_t     new_pair,
    input  wqs_pkg::pair_t     left_pair,
    input  logic               left_gt,
    input  logic               left_valid,
    input  wqs_pkg::pair_t     right_pair,
    input  logic               self_valid,
    output wqs_pkg::pair_t     pair,
    output logic               gt
);
    import wqs_pkg::*;

    pair_t pair_reg;
    pair_t pair_next;

    // The stored label is strictly greater than the incoming one, so it moves right.
    assign gt   = self_valid && (pair_reg.label > new_pair.label);
    assign pair = pair_reg;

    // Pop shifts toward the head; insert shifts greater labels away from it.
    always_comb begin
        pair_next = pair_reg;
        if (ctrl.pop) begin
            pair_next = right_pair;
        end else if (ctrl.insert) begin
            if (left_gt) begin
                pair_next = left_pair;
            end else if (gt || (!self_valid && left_valid)) begin
                pair_next = new_pair;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pair_reg <= pair_next;
    end

endmodule

@@ src/weighted_quantile_select.sv @@
// Weighted lower quantile selector: top level with control and scan datapath.
//
// Pairs of (label, weight) arrive on the s_ channel, one transfer per cycle,
// and are insertion-sorted by signed label into a chain of MAX_ITEMS cells
// while their weights are summed. The pair with s_last_item set closes the
// set: the threshold alpha * total is then formed by a single
// multiplier, then the chain is shifted toward its head one pair per cycle
// while a running weight is compared with that threshold. The first label
// that reaches it (or the largest label) is sent on the m_ channel with a
// status code; a zero total gives STATUS_ZERO with no scan. The input
// is closed while the threshold and scan run. Pairs beyond MAX_ITEMS are
// dropped and flagged. The result waits in an output register while
// m_ready is low; new pairs are taken meanwhile, and a finished scan holds
// until the register is free. Reset (aresetn low, synchronous) empties the
// set, clears the output and loads alpha with one half.
module weighted_quantile_select #(
    parameter int MAX_ITEMS = wqs_pkg::MAX_ITEMS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration port.
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [wqs_pkg::PADDR_W-1:0]           paddr,
    input  logic [wqs_pkg::PDATA_W-1:0]           pwdata,
    output logic [wqs_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready,
    // Input pairs.
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [wqs_pkg::LABEL_W-1:0]    s_label_value,
    input  logic [wqs_pkg::WEIGHT_W-1:0]          s_sample_weight,
    input  logic                                  s_last_item,
    // Results.
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [wqs_pkg::LABEL_W-1:0]    m_quantile_value,
    output logic [wqs_pkg::STATUS_W-1:0]          m_status
);
    import wqs_pkg::*;

    localparam int COUNT_W = $clog2(MAX_ITEMS + 1);
    localparam int TOTAL_W = WEIGHT_W + $clog2(MAX_ITEMS);
    localparam int THR_W   = TOTAL_W + ALPHA_W;

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_THRESH  = 2'd1;
    localparam logic [1:0] ST_SCAN    = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [TOTAL_W-1:0]        total_reg, total_next;
    logic                      overflow_reg, overflow_next;
    logic [THR_W-1:0]          thr_reg, thr_next;
    logic [TOTAL_W-1:0]        run_reg, run_next;
    logic [ALPHA_W-1:0]        alpha_reg;
    logic                      m_valid_reg, m_valid_next;
    logic signed [LABEL_W-1:0] m_value_reg, m_value_next;
    logic [STATUS_W-1:0]       m_status_reg, m_status_next;

    pair_t      new_pair;
    cell_ctrl_t ctrl;
    pair_t      cell_pair  [MAX_ITEMS];
    logic       cell_gt    [MAX_ITEMS];
    logic       cell_valid [MAX_ITEMS];

    logic               s_fire;
    logic               room;
    logic               out_free;
    logic [TOTAL_W-1:0] run_sum;
    logic               hit;
    logic               scan_end;

    // Configuration register access.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_ALPHA) begin
            alpha_reg <= pwdata[ALPHA_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_ALPHA) begin
            prdata = {{(PDATA_W-ALPHA_W){1'b0}}, alpha_reg};
        end
    end

    // Handshake and chain control.
    assign s_ready  = (state_reg == ST_COLLECT);
    assign s_fire   = s_valid && s_ready;
    assign room     = (count_reg < COUNT_W'(MAX_ITEMS));
    assign out_free = !m_valid_reg || m_ready;

    assign new_pair.label  = s_label_value;
    assign new_pair.weight = s_sample_weight;

    // Running weight over the head of the chain, compared in Q38.16 at the default MAX_ITEMS.
    assign run_sum  = run_reg + TOTAL_W'(cell_pair[0].weight);
    assign hit      = ({run_sum, {ALPHA_W{1'b0}}} >= thr_reg);
    assign scan_end = hit || (count_reg == COUNT_W'(1));

    assign ctrl.insert = s_fire && room;
    assign ctrl.pop    = (state_reg == ST_SCAN) && !scan_end;

    // The chain of sorting cells.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            pair_t left_pair;
            pair_t right_pair;
            logic  left_gt;
            logic  left_valid;

            assign cell_valid[gi] = (COUNT_W'(gi) < count_reg);

            if (gi == 0) begin : g_head
                assign left_pair  = new_pair;
                assign left_gt    = 1'b0;
                assign left_valid = 1'b1;
            end else begin : g_body
                assign left_pair  = cell_pair[gi-1];
                assign left_gt    = cell_gt[gi-1];
                assign left_valid = cell_valid[gi-1];
            end

            if (gi == MAX_ITEMS - 1) begin : g_tail
                assign right_pair = cell_pair[gi];
            end else begin : g_inner
                assign right_pair = cell_pair[gi+1];
            end

            wqs_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .new_pair   (new_pair),
                .left_pair  (left_pair),
                .left_gt    (left_gt),
                .left_valid (left_valid),
                .right_pair (right_pair),
                .self_valid (cell_valid[gi]),
                .pair       (cell_pair[gi]),
                .gt         (cell_gt[gi])
            );
        end
    endgenerate

    // Sequencer: collect, form the threshold, then scan the chain; a zero total skips the scan.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        overflow_next = overflow_reg;
        thr_next      = thr_reg;
        run_next      = run_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        case (state_reg)
            ST_COLLECT: begin
                if (s_fire) begin
                    if (room) begin
                        count_next = count_reg + COUNT_W'(1);
                        total_next = total_reg + TOTAL_W'(s_sample_weight);
                    end else begin
                        overflow_next = 1'b1;
                    end
                    if (s_last_item) begin
                        state_next = ST_THRESH;
                    end
                end
            end
            ST_THRESH: begin
                if (total_reg == '0) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_value_next  = '0;
                        m_status_next = STATUS_ZERO;
                        count_next    = '0;
                        total_next    = '0;
                        overflow_next = 1'b0;
                        state_next    = ST_COLLECT;
                    end
                end else begin
                    thr_next   = THR_W'(alpha_reg) * THR_W'(total_reg);
                    run_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!scan_end) begin
                    run_next   = run_sum;
                    count_next = count_reg - COUNT_W'(1);
                end else if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = cell_pair[0].label;
                    m_status_next = overflow_reg ? STATUS_DROP : STATUS_OK;
                    count_next    = '0;
                    total_next    = '0;
                    overflow_next = 1'b0;
                    state_next    = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_COLLECT;
            count_reg    <= '0;
            total_reg    <= '0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            overflow_reg <= overflow_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        thr_reg      <= thr_next;
        run_reg      <= run_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_quantile_value = m_value_reg;
    assign m_status         = m_status_reg;

endmodule

@@ sim/tb_weighted_quantile_select.sv @@
// Self-checking testbench for the weighted quantile selector.
`timescale 1ns / 1ps

module tb_weighted_quantile_select;
    import wqs_pkg::*;

    localparam int SET_CAP      = MAX_ITEMS_DEF;
    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_TICKS = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 6;
    localparam int PHASE_PAIRS  = 70;

    // One result of the block.
    typedef struct packed {
        logic signed [LABEL_W-1:0] value;
        logic [STATUS_W-1:0]       status;
    } quantile_t;

    // One row of directed stimulus; a row may repeat its pair several times.
    typedef struct packed {
        logic signed [LABEL_W-1:0] label;
        logic [WEIGHT_W-1:0]       weight;
        logic                      last;
        logic [7:0]                reps;
        logic                      typed;
        logic signed [LABEL_W-1:0] want_value;
        logic [STATUS_W-1:0]       want_status;
    } pair_row_t;

    localparam int ROWS = 18;
    localparam pair_row_t PAIR_TABLE [ROWS] = '{
        // Largest label alone.
        '{32'h7FFF_FFFF, 32'd1,         1'b1, 8'd1,  1'b1, 32'h7FFF_FFFF, STATUS_OK},
        // Smallest label with the largest weight.
        '{32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 8'd1,  1'b1, 32'h8000_0000, STATUS_OK},
        // Zero total weight, single pair and two pairs.
        '{32'd123,       32'd0,         1'b1, 8'd1,  1'b1, 32'd0,         STATUS_ZERO},
        '{32'd10,        32'd0,         1'b0, 8'd1,  1'b0, 32'd0,         STATUS_OK},
        '{32'd20,        32'd0,         1'b1, 8'd1,  1'b1, 32'd0,         STATUS_ZERO},
        // Unsorted arrival with a negative label.
        '{-32'sd5,       32'd1,         1'b0, 8'd1,  1'b0, 32'd0,         STATUS_OK},
        '{32'd100,       32'd1,         1'b0, 8'd1,  1'b0, 32'd0,         STATUS_OK},
        '{32'd3,         32'd2,         1'b1, 8'd1,  1'b0, 32'd0,         STATUS_OK},
        // Extreme labels, all at full weight.
        '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'd1,  1'b0, 32'd0,         STATUS_OK},
        '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 8'd1,  1'b0, 32'd0,         STATUS_OK},
        '{32'd0,         32'hFFFF_FFFF, 1'b1, 8'd1,  1'b0, 32'd0,         STATUS_OK},
        // Equal labels.
        '{32'd42,        32'd5,         1'b0, 8'd2,  1'b0, 32'd0,         STATUS_OK},
        '{-32'sd42,      32'd1,         1'b0, 8'd1,  1'b0, 32'd0,         STATUS_OK},
        '{32'd42,        32'd3,         1'b1, 8'd1,  1'b0, 32'd0,         STATUS_OK},
        // A full set; the closing pair is dropped.
        '{32'd5,         32'd1,         1'b0, 8'd64, 1'b0, 32'd0,         STATUS_OK},
        '{-32'sd1,       32'd100,       1'b1, 8'd1,  1'b1, 32'd5,         STATUS_DROP},
        // A full set of zero weights: zero total wins over the drop.
        '{32'd9,         32'd0,         1'b0, 8'd64, 1'b0, 32'd0,         STATUS_OK},
        '{-32'sd1,       32'd7,         1'b1, 8'd1,  1'b1, 32'd0,         STATUS_ZERO}
    };

    logic                        aclk;
    logic                        aresetn = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [PADDR_W-1:0]          paddr = '0;
    logic [PDATA_W-1:0]          pwdata = '0;
    logic [PDATA_W-1:0]          prdata;
    logic                        pready;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [LABEL_W-1:0]   s_label_value = '0;
    logic [WEIGHT_W-1:0]         s_sample_weight = '0;
    logic                        s_last_item = 1'b0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [LABEL_W-1:0]   m_quantile_value;
    logic [STATUS_W-1:0]         m_status;

    // Shadow state of the selector.
    logic signed [LABEL_W-1:0]   kept_label [SET_CAP];
    logic [WEIGHT_W-1:0]         kept_weight [SET_CAP];
    int                          kept_count = 0;
    logic [63:0]                 kept_total = '0;
    bit                          pairs_dropped = 1'b0;
    logic [ALPHA_W-1:0]          alpha_shadow = ALPHA_RESET;

    quantile_t                   pending_results [$];
    int                          mismatch_count = 0;
    int                          stall_ticks = 0;
    bit                          calm = 1'b0;
    bit                          hold_armed = 1'b0;
    bit                          hold_done = 1'b0;

    weighted_quantile_select uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_label_value    (s_label_value),
        .s_sample_weight  (s_sample_weight),
        .s_last_item      (s_last_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_quantile_value (m_quantile_value),
        .m_status         (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Folds one pair into the shadow set; returns 1 when the pair closes a set.
    function automatic bit fold_pair(input logic signed [LABEL_W-1:0] lbl,
                                     input logic [WEIGHT_W-1:0] wgt,
                                     input logic lst,
                                     output quantile_t res);
        int          pos;
        logic [63:0] limit_q;
        logic [63:0] run_q;
        bit          hit;
        res = '0;
        // Insertion after any stored pairs with an equal label.
        if (kept_count < SET_CAP) begin
            pos = kept_count;
            while (pos > 0 && kept_label[pos-1] > lbl) begin
                kept_label[pos]  = kept_label[pos-1];
                kept_weight[pos] = kept_weight[pos-1];
                pos--;
            end
            kept_label[pos]  = lbl;
            kept_weight[pos] = wgt;
            kept_count++;
            kept_total += 64'(wgt);
        end else begin
            pairs_dropped = 1'b1;
        end
        if (!lst) begin
            return 1'b0;
        end
        // Cumulative scan against alpha times the total, both in Q48.16.
        if (kept_total == 0) begin
            res.status = STATUS_ZERO;
        end else begin
            limit_q = 64'(alpha_shadow) * kept_total;
            run_q   = '0;
            hit     = 1'b0;
            for (int i = 0; i < kept_count; i++) begin
                run_q += 64'(kept_weight[i]);
                if (!hit && (run_q << 16) >= limit_q) begin
                    res.value = kept_label[i];
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                res.value = kept_label[kept_count-1];
            end
            res.status = pairs_dropped ? STATUS_DROP : STATUS_OK;
        end
        kept_count    = 0;
        kept_total    = '0;
        pairs_dropped = 1'b0;
        return 1'b1;
    endfunction

    // Offers one pair, waits for its transfer and records what it should yield.
    task automatic send_pair(input logic signed [LABEL_W-1:0] lbl,
                             input logic [WEIGHT_W-1:0] wgt,
                             input logic lst,
                             input logic typed,
                             input quantile_t typed_want);
        quantile_t predicted;
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_label_value   <= lbl;
        s_sample_weight <= wgt;
        s_last_item     <= lst;
        do @(posedge aclk); while (!s_ready);
        if (fold_pair(lbl, wgt, lst, predicted)) begin
            pending_results = {pending_results, (typed ? typed_want : predicted)};
        end
    endtask

    // One APB transfer to the alpha register.
    task automatic apb_transfer(input bit is_write, input logic [PDATA_W-1:0] wdata,
                                output logic [PDATA_W-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_ALPHA;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (is_write) begin
            alpha_shadow = wdata[ALPHA_W-1:0];
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Waits for every pending result, then lets the scan pipeline go quiet.
    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // Result side: random back-pressure plus one long hold-off.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_armed && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 11);
            end
        end
    end

    // Compare each result transfer with the oldest expected one.
    always @(posedge aclk) begin
        quantile_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result value=%h status=%0d",
                                        m_quantile_value, m_status));
            end else begin
                want = pending_results.pop_front();
                if (m_quantile_value !== want.value) begin
                    flag_mismatch($sformatf("quantile_value expected %h got %h",
                                            want.value, m_quantile_value));
                end
                if (m_status !== want.status) begin
                    flag_mismatch($sformatf("status expected %0d got %0d",
                                            want.status, m_status));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)
            || !aresetn) begin
            stall_ticks <= 0;
        end else if (stall_ticks >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_ticks <= stall_ticks + 1;
        end
    end

    initial begin
        logic [PDATA_W-1:0]        rd;
        logic [ALPHA_W-1:0]        next_alpha;
        logic signed [LABEL_W-1:0] lbl;
        logic [WEIGHT_W-1:0]       wgt;
        int                        sent;
        int                        len;
        int                        label_mode;
        int                        weight_mode;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The alpha register must come out of reset at one half.
        apb_transfer(1'b0, '0, rd);
        if (rd[ALPHA_W-1:0] !== ALPHA_RESET) begin
            flag_mismatch($sformatf("alpha after reset expected %h got %h",
                                    ALPHA_RESET, rd[ALPHA_W-1:0]));
        end

        // Directed table at the reset alpha.
        for (int r = 0; r < ROWS; r++) begin
            repeat (PAIR_TABLE[r].reps) begin
                send_pair(PAIR_TABLE[r].label, PAIR_TABLE[r].weight, PAIR_TABLE[r].last,
                          PAIR_TABLE[r].typed,
                          '{PAIR_TABLE[r].want_value, PAIR_TABLE[r].want_status});
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // Random sets, one alpha setting per phase.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: next_alpha = 16'd1;
                1: next_alpha = 16'hFFFF;
                2: next_alpha = 16'd0;
                4: next_alpha = ALPHA_RESET;
                default: next_alpha = 16'($urandom);
            endcase
            apb_transfer(1'b1, {16'($urandom), next_alpha}, rd);
            apb_transfer(1'b0, '0, rd);
            if (rd[ALPHA_W-1:0] !== next_alpha) begin
                flag_mismatch($sformatf("alpha readback expected %h got %h",
                                        next_alpha, rd[ALPHA_W-1:0]));
            end
            calm = (ph == 1);
            if (ph == 3) begin
                hold_armed = 1'b1;
            end

            sent = 0;
            while (sent < PHASE_PAIRS) begin
                // Mostly short sets; now and then a long one that may overrun the store.
                len = ($urandom_range(99) < 4) ? $urandom_range(70, 62) : $urandom_range(12, 1);
                label_mode  = $urandom_range(3);
                weight_mode = $urandom_range(9);
                for (int i = 0; i < len; i++) begin
                    case (label_mode)
                        0: lbl = $urandom;
                        1: lbl = $signed(32'($urandom_range(6))) - 32'sd3;
                        2: lbl = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(2)
                                                   : 32'h8000_0000 + $urandom_range(2);
                        default: lbl = $signed($urandom) >>> $urandom_range(31);
                    endcase
                    case (weight_mode)
                        0: wgt = '0;
                        1: wgt = 32'hFFFF_FFFF;
                        2: wgt = $urandom_range(3);
                        3: wgt = $urandom >> $urandom_range(31);
                        default: wgt = $urandom;
                    endcase
                    send_pair(lbl, wgt, (i == len - 1), 1'b0, '0);
                end
                sent += len;
            end
            @(negedge aclk);
            s_valid <= 1'b0;
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
